FILE: hdl/cdn_pkg.sv
// Package for the calendar date navigator: command codes, stage payload types,
// month tables and the small date functions used by the pipeline stages.
// Depends on nothing.
`default_nettype none

package cdn_pkg;

  typedef enum logic [3:0] {
    CMD_DAY_DEC   = 4'd0,
    CMD_DAY_INC   = 4'd1,
    CMD_WEEK_DEC  = 4'd2,
    CMD_WEEK_INC  = 4'd3,
    CMD_MONTH_DEC = 4'd4,
    CMD_MONTH_INC = 4'd5,
    CMD_YEAR_DEC  = 4'd6,
    CMD_YEAR_INC  = 4'd7,
    CMD_LOAD      = 4'd8
  } cmd_e;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  // Years are kept as century (0..99) and year within century (0..99).
  localparam logic [6:0]  CENT_LAST  = 7'd99;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;
  localparam logic [12:0] RECIP_100  = 13'd5243;  // 2^19 / 100, rounded up
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [2:0] WD_OFFSET [12] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
  };

  // Command after the load year has been split into century and remainder.
  typedef struct packed {
    logic [3:0] command;
    logic [6:0] load_cent;
    logic [6:0] load_rem;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic       load_bad;
  } cmd_t;

  // Date held by the state stage, year in split form.
  typedef struct packed {
    logic [6:0] cent;
    logic [6:0] rem;
    logic [3:0] month;
    logic [4:0] day;
    logic       range_error;
  } date_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  month_length;
    logic [2:0]  leading_blanks;
    logic        range_error;
  } res_t;

  // Since 100 is a multiple of 4, divisibility by 4 only depends on the remainder.
  function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] rem);
    is_leap = ((rem[1:0] == 2'd0) && (rem != 7'd0)) ||
              ((rem == 7'd0) && (cent[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] last_day(input logic leap, input logic [3:0] month);
    logic [3:0] m;
    m = (month > MONTH_DEC) ? MONTH_DEC : month;
    if ((m == MONTH_FEB) && leap) begin
      last_day = 5'd29;
    end else begin
      last_day = MONTH_LEN[m];
    end
  endfunction

  function automatic logic [4:0] clamp_day(input logic [4:0] day, input logic [4:0] last);
    if (day == 5'd0) begin
      clamp_day = 5'd1;
    end else if (day > last) begin
      clamp_day = last;
    end else begin
      clamp_day = day;
    end
  endfunction

  // Weekday, 0 Sunday. With yy = 100*C + R the usual sum reduces, modulo 7,
  // to 5*C + C/4 + R + R/4 + offset + day. January and February count
  // against the previous year.
  function automatic logic [2:0] weekday(input logic [6:0] cent, input logic [6:0] rem,
                                         input logic [3:0] month, input logic [4:0] day);
    logic [6:0] cc;
    logic [6:0] rr;
    logic [3:0] m;
    logic [9:0] s;
    logic [4:0] t;
    logic [3:0] u;
    cc = cent;
    rr = rem;
    m  = (month > MONTH_DEC) ? MONTH_DEC : month;
    if (m <= MONTH_FEB) begin
      if (rem == 7'd0) begin
        cc = cent - 7'd1;
        rr = CENT_LAST;
      end else begin
        rr = rem - 7'd1;
      end
    end
    s = 10'({cc, 2'b00}) + 10'(cc) + 10'(cc[6:2]) + 10'(rr) + 10'(rr[6:2]) +
        10'(WD_OFFSET[m]) + 10'(day);
    // 8 is 1 modulo 7, so octal digits can be summed.
    t = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[9]);
    u = 4'(t[2:0]) + 4'(t[4:3]);
    weekday = (u >= 4'd7) ? 3'(u - 4'd7) : u[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cdn_in_if.sv
// Command channel of the calendar date navigator: valid, ready and the command fields.
// Depends on nothing.
`default_nettype none

interface cdn_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [13:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;

  modport source (output valid, output command, output load_year, output load_month,
                  output load_day, input ready);
  modport sink (input valid, input command, input load_year, input load_month,
                input load_day, output ready);
endinterface

`default_nettype wire

FILE: hdl/cdn_out_if.sv
// Result channel of the calendar date navigator: valid, ready and the result fields.
// Depends on nothing.
`default_nettype none

interface cdn_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  month_length;
  logic [2:0]  leading_blanks;
  logic        range_error;

  modport source (output valid, output year, output month, output day, output weekday,
                  output month_length, output leading_blanks, output range_error,
                  input ready);
  modport sink (input valid, input year, input month, input day, input weekday,
                input month_length, input leading_blanks, input range_error,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/cdn_load_split.sv
// Input stage: registers a command and splits the load year into century and
// remainder by a reciprocal multiply. Depends on cdn_pkg.
`default_nettype none

module cdn_load_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       command_i,
  input  logic [13:0]      load_year_i,
  input  logic [3:0]       load_month_i,
  input  logic [4:0]       load_day_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cdn_pkg::cmd_t    out_cmd_o
);

  logic          valid_q, valid_d;
  cdn_pkg::cmd_t cmd_q, cmd_d;
  logic [26:0]   prod;
  logic [6:0]    cent;
  logic [13:0]   rem_wide;

  assign in_ready_o = !valid_q || out_ready_i;

  // Exact quotient by 100 for every year up to 9999; larger years are flagged bad.
  always_comb begin
    prod     = 27'(load_year_i) * 27'(cdn_pkg::RECIP_100);
    cent     = prod[cdn_pkg::RECIP_SHIFT +: 7];
    rem_wide = load_year_i - 14'({cent, 6'b0}) - 14'({cent, 5'b0}) - 14'({cent, 2'b0});
    cmd_d.command    = command_i;
    cmd_d.load_cent  = cent;
    cmd_d.load_rem   = rem_wide[6:0];
    cmd_d.load_month = load_month_i;
    cmd_d.load_day   = load_day_i;
    cmd_d.load_bad   = (load_year_i == 14'd0) || (load_year_i > cdn_pkg::YEAR_LAST) ||
                       (load_month_i > cdn_pkg::MONTH_DEC);
    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;

endmodule

`default_nettype wire

FILE: hdl/cdn_date_step.sv
// State stage: holds the current date and applies one command per transfer,
// with carries, clamping and range checks. Depends on cdn_pkg.
`default_nettype none

module cdn_date_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cdn_pkg::cmd_t    in_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cdn_pkg::date_t   out_date_o
);

  logic              valid_q, valid_d;
  logic [6:0]        cent_q, cent_d;
  logic [6:0]        rem_q, rem_d;
  logic [3:0]        mon_q, mon_d;
  logic [4:0]        day_q, day_d;
  logic              err_q, err_d;

  logic [6:0]        inc_cent, inc_rem, dec_cent, dec_rem;
  logic              at_max, at_min;
  logic              leap_cur, leap_inc, leap_dec, leap_load;
  logic [4:0]        len_cur, len_prev, len_next;
  logic signed [6:0] delta, dsum, wrap_dn, wrap_up;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    at_max   = (cent_q == cdn_pkg::CENT_LAST) && (rem_q == cdn_pkg::CENT_LAST);
    at_min   = (cent_q == 7'd0) && (rem_q == 7'd1);
    inc_cent = (rem_q == cdn_pkg::CENT_LAST) ? cent_q + 7'd1 : cent_q;
    inc_rem  = (rem_q == cdn_pkg::CENT_LAST) ? 7'd0 : rem_q + 7'd1;
    dec_cent = (rem_q == 7'd0) ? cent_q - 7'd1 : cent_q;
    dec_rem  = (rem_q == 7'd0) ? cdn_pkg::CENT_LAST : rem_q - 7'd1;

    leap_cur  = cdn_pkg::is_leap(cent_q, rem_q);
    leap_inc  = cdn_pkg::is_leap(inc_cent, inc_rem);
    leap_dec  = cdn_pkg::is_leap(dec_cent, dec_rem);
    leap_load = cdn_pkg::is_leap(in_cmd_i.load_cent, in_cmd_i.load_rem);

    // Neighbor months within the same year; the wrap cases are 31-day months.
    len_cur  = cdn_pkg::last_day(leap_cur, mon_q);
    len_prev = (mon_q == cdn_pkg::MONTH_JAN) ? 5'd31 :
               cdn_pkg::last_day(leap_cur, mon_q - 4'd1);
    len_next = (mon_q == cdn_pkg::MONTH_DEC) ? 5'd31 :
               cdn_pkg::last_day(leap_cur, mon_q + 4'd1);

    case (in_cmd_i.command)
      cdn_pkg::CMD_DAY_DEC:  delta = -7'sd1;
      cdn_pkg::CMD_DAY_INC:  delta = 7'sd1;
      cdn_pkg::CMD_WEEK_DEC: delta = -7'sd7;
      cdn_pkg::CMD_WEEK_INC: delta = 7'sd7;
      default:               delta = 7'sd0;
    endcase
    dsum    = $signed({2'b00, day_q}) + delta;
    wrap_dn = dsum + $signed({2'b00, len_prev});
    wrap_up = dsum - $signed({2'b00, len_cur});

    cent_d = cent_q;
    rem_d  = rem_q;
    mon_d  = mon_q;
    day_d  = day_q;
    err_d  = 1'b0;

    unique case (in_cmd_i.command)
      cdn_pkg::CMD_DAY_DEC, cdn_pkg::CMD_DAY_INC,
      cdn_pkg::CMD_WEEK_DEC, cdn_pkg::CMD_WEEK_INC: begin
        if (dsum < 7'sd1) begin
          if (mon_q == cdn_pkg::MONTH_JAN) begin
            if (at_min) begin
              err_d = 1'b1;
            end else begin
              cent_d = dec_cent;
              rem_d  = dec_rem;
              mon_d  = cdn_pkg::MONTH_DEC;
              day_d  = wrap_dn[4:0];
            end
          end else begin
            mon_d = mon_q - 4'd1;
            day_d = wrap_dn[4:0];
          end
        end else if (dsum > $signed({2'b00, len_cur})) begin
          if (mon_q == cdn_pkg::MONTH_DEC) begin
            if (at_max) begin
              err_d = 1'b1;
            end else begin
              cent_d = inc_cent;
              rem_d  = inc_rem;
              mon_d  = cdn_pkg::MONTH_JAN;
              day_d  = wrap_up[4:0];
            end
          end else begin
            mon_d = mon_q + 4'd1;
            day_d = wrap_up[4:0];
          end
        end else begin
          day_d = dsum[4:0];
        end
      end
      cdn_pkg::CMD_MONTH_DEC: begin
        if (mon_q == cdn_pkg::MONTH_JAN) begin
          if (at_min) begin
            err_d = 1'b1;
          end else begin
            cent_d = dec_cent;
            rem_d  = dec_rem;
            mon_d  = cdn_pkg::MONTH_DEC;
            day_d  = cdn_pkg::clamp_day(day_q, len_prev);
          end
        end else begin
          mon_d = mon_q - 4'd1;
          day_d = cdn_pkg::clamp_day(day_q, len_prev);
        end
      end
      cdn_pkg::CMD_MONTH_INC: begin
        if (mon_q == cdn_pkg::MONTH_DEC) begin
          if (at_max) begin
            err_d = 1'b1;
          end else begin
            cent_d = inc_cent;
            rem_d  = inc_rem;
            mon_d  = cdn_pkg::MONTH_JAN;
            day_d  = cdn_pkg::clamp_day(day_q, len_next);
          end
        end else begin
          mon_d = mon_q + 4'd1;
          day_d = cdn_pkg::clamp_day(day_q, len_next);
        end
      end
      cdn_pkg::CMD_YEAR_DEC: begin
        if (at_min) begin
          err_d = 1'b1;
        end else begin
          cent_d = dec_cent;
          rem_d  = dec_rem;
          day_d  = cdn_pkg::clamp_day(day_q, cdn_pkg::last_day(leap_dec, mon_q));
        end
      end
      cdn_pkg::CMD_YEAR_INC: begin
        if (at_max) begin
          err_d = 1'b1;
        end else begin
          cent_d = inc_cent;
          rem_d  = inc_rem;
          day_d  = cdn_pkg::clamp_day(day_q, cdn_pkg::last_day(leap_inc, mon_q));
        end
      end
      cdn_pkg::CMD_LOAD: begin
        if (in_cmd_i.load_bad) begin
          err_d = 1'b1;
        end else begin
          cent_d = in_cmd_i.load_cent;
          rem_d  = in_cmd_i.load_rem;
          mon_d  = in_cmd_i.load_month;
          day_d  = cdn_pkg::clamp_day(in_cmd_i.load_day,
                     cdn_pkg::last_day(leap_load, in_cmd_i.load_month));
        end
      end
      default: begin
        err_d = 1'b0;
      end
    endcase

    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cent_q  <= 7'd20;
      rem_q   <= 7'd0;
      mon_q   <= cdn_pkg::MONTH_JAN;
      day_q   <= 5'd1;
      err_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (in_valid_i && in_ready_o) begin
        cent_q <= cent_d;
        rem_q  <= rem_d;
        mon_q  <= mon_d;
        day_q  <= day_d;
        err_q  <= err_d;
      end
    end
  end

  assign out_valid_o            = valid_q;
  assign out_date_o.cent        = cent_q;
  assign out_date_o.rem         = rem_q;
  assign out_date_o.month       = mon_q;
  assign out_date_o.day         = day_q;
  assign out_date_o.range_error = err_q;

endmodule

`default_nettype wire

FILE: hdl/cdn_result_calc.sv
// Result stage: turns the held date into year, weekday, month length and grid
// offset, and holds the result until it is taken. Depends on cdn_pkg.
`default_nettype none

module cdn_result_calc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cdn_pkg::date_t   in_date_i,
  input  logic             week_start_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cdn_pkg::res_t    out_res_o
);

  logic          valid_q, valid_d;
  cdn_pkg::res_t res_q, res_d;
  logic [2:0]    first_wd;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    first_wd = cdn_pkg::weekday(in_date_i.cent, in_date_i.rem, in_date_i.month, 5'd1);
    res_d.year = 14'({in_date_i.cent, 6'b0}) + 14'({in_date_i.cent, 5'b0}) +
                 14'({in_date_i.cent, 2'b0}) + 14'(in_date_i.rem);
    res_d.month   = in_date_i.month;
    res_d.day     = in_date_i.day;
    res_d.weekday = cdn_pkg::weekday(in_date_i.cent, in_date_i.rem, in_date_i.month,
                                     in_date_i.day);
    res_d.month_length = cdn_pkg::last_day(cdn_pkg::is_leap(in_date_i.cent, in_date_i.rem),
                                           in_date_i.month);
    // Monday start shifts the grid one column left, Sunday wrapping to the end.
    if (week_start_i) begin
      res_d.leading_blanks = (first_wd == 3'd0) ? 3'd6 : first_wd - 3'd1;
    end else begin
      res_d.leading_blanks = first_wd;
    end
    res_d.range_error = in_date_i.range_error;
    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

FILE: hdl/calendar_date_navigator.sv
// Calendar date navigator top level: load split, date state and result stages.
// A command passes through one register each in the split, state and result
// stages before its result is offered. One command is taken per cycle unless
// the result sink holds ready low; the date register loop closes within the
// state stage, so each command sees the date left by the one before.
// Reset: date 1 January 2000, week start Monday, all stages empty.
`default_nettype none

module calendar_date_navigator (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  cdn_in_if.sink    cmd_ch,
  cdn_out_if.source res_ch
);

  // Week start register: 0 puts Sunday in the first grid column, 1 Monday.
  // The user must write it only while no command is in flight; the block does not enforce this.
  logic week_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      week_start_q <= 1'b1;
    end else if (cfg_we_i) begin
      week_start_q <= cfg_wdata_i;
    end
  end

  // Stage handshakes. Every stage takes a new transfer whenever it is empty
  // or its current item leaves in the same cycle, so the pipeline only stops
  // when the result sink holds ready low.
  logic           split_valid, split_ready;
  cdn_pkg::cmd_t  split_cmd;
  logic           step_valid, step_ready;
  cdn_pkg::date_t step_date;
  cdn_pkg::res_t  res;

  // First stage: register the command and split the load year.
  cdn_load_split u_load_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_ch.valid),
    .in_ready_o   (cmd_ch.ready),
    .command_i    (cmd_ch.command),
    .load_year_i  (cmd_ch.load_year),
    .load_month_i (cmd_ch.load_month),
    .load_day_i   (cmd_ch.load_day),
    .out_valid_o  (split_valid),
    .out_ready_i  (split_ready),
    .out_cmd_o    (split_cmd)
  );

  // Second stage: the date itself. Its registers double as the stage payload.
  cdn_date_step u_date_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_cmd_i    (split_cmd),
    .out_valid_o (step_valid),
    .out_ready_i (step_ready),
    .out_date_o  (step_date)
  );

  // Third stage: derived fields, held in the output register.
  cdn_result_calc u_result_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (step_valid),
    .in_ready_o   (step_ready),
    .in_date_i    (step_date),
    .week_start_i (week_start_q),
    .out_valid_o  (res_ch.valid),
    .out_ready_i  (res_ch.ready),
    .out_res_o    (res)
  );

  assign res_ch.year           = res.year;
  assign res_ch.month          = res.month;
  assign res_ch.day            = res.day;
  assign res_ch.weekday        = res.weekday;
  assign res_ch.month_length   = res.month_length;
  assign res_ch.leading_blanks = res.leading_blanks;
  assign res_ch.range_error    = res.range_error;

endmodule

`default_nettype wire

FILE: hdl/cdn_checker.sv
// Port checker for the calendar date navigator, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module cdn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [13:0] year_i,
  input logic [3:0]  month_i,
  input logic [4:0]  day_i,
  input logic [4:0]  month_length_i,
  input logic [2:0]  leading_blanks_i
);

  // A held result stays valid and keeps its year, month and day.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(year_i) && $stable(month_i) &&
    $stable(day_i))
    else $error("result changed while stalled");

  // The command side only stops when a full pipeline meets a stalled sink.
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("command side stalled without backpressure");

  // Every reported date is a real date within the year range.
  a_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> day_i >= 5'd1 && day_i <= month_length_i && month_i <= 4'd11 &&
    year_i >= 14'd1 && year_i <= 14'd9999 && leading_blanks_i <= 3'd6)
    else $error("result date out of range");

  // Only February has fewer than 30 days.
  a_feb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && month_length_i < 5'd30 |-> month_i == 4'd1)
    else $error("short month other than February");

endmodule

bind calendar_date_navigator cdn_checker u_cdn_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (cmd_ch.ready),
  .out_valid_i      (res_ch.valid),
  .out_ready_i      (res_ch.ready),
  .year_i           (res_ch.year),
  .month_i          (res_ch.month),
  .day_i            (res_ch.day),
  .month_length_i   (res_ch.month_length),
  .leading_blanks_i (res_ch.leading_blanks)
);

`default_nettype wire
